// File: src/tdr_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and codes of the table dfa recognizer
package tdr_pkg;

    // table shape
    localparam int ROWS   = 16;
    localparam int COLS   = 4;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_AW = (COLS > 1) ? $clog2(COLS) : 1;

    // next-state store, addressed by {row, column}
    localparam int CELL_AW = ROW_AW + COL_AW;
    localparam int CELLS   = 1 << CELL_AW;

    // field widths fixed by the item format
    localparam int OP_W   = 3;
    localparam int RIDX_W = 4;
    localparam int CIDX_W = 2;
    localparam int CHAR_W = 8;
    localparam int VERD_W = 2;

    // final state characters
    localparam int NFINAL  = 5;
    localparam int FCNT_W  = 3;
    localparam int FIDX_W  = $clog2(NFINAL);

    // configuration port
    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] CFG_START = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_FCNT  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_FA    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_FB    = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_FC    = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_FD    = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_FE    = 3'd6;

    // command queue
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_ROW  = 3'd0,
        OP_COL  = 3'd1,
        OP_SET  = 3'd2,
        OP_FEED = 3'd3,
        OP_END  = 3'd4
    } t_op;

    typedef enum logic [VERD_W-1:0] {
        V_ACCEPT = 2'd0,
        V_REJECT = 2'd1,
        V_DEAD   = 2'd2
    } t_verdict;

    typedef struct packed {
        t_op               op;
        logic [ROW_AW-1:0] row;
        logic [COL_AW-1:0] col;
        logic [CHAR_W-1:0] ch;
    } t_cmd;

    typedef struct packed {
        logic              we;
        logic [CFG_AW-1:0] idx;
        logic [CHAR_W-1:0] data;
    } t_cfg_wr;

endpackage

// File: src/tdr_in_if.sv
`timescale 1ns / 1ps
// input channel: table loads, symbols and end marks
interface tdr_in_if;
    import tdr_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [RIDX_W-1:0] row_index;
    logic [CIDX_W-1:0] col_index;
    logic [CHAR_W-1:0] char_value;

    modport source (output valid, op, row_index, col_index, char_value, input ready);
    modport sink   (input valid, op, row_index, col_index, char_value, output ready);
endinterface

// File: src/tdr_out_if.sv
`timescale 1ns / 1ps
// output channel: one verdict per string
interface tdr_out_if;
    import tdr_pkg::*;

    logic              valid;
    logic              ready;
    logic [VERD_W-1:0] verdict;
    logic [CHAR_W-1:0] end_state;

    modport source (output valid, verdict, end_state, input ready);
    modport sink   (input valid, verdict, end_state, output ready);
endinterface

// File: src/table_dfa_recognizer_top.sv
`timescale 1ns / 1ps
// top level of the table dfa recognizer
// an end beat passes from the command queue into the verdict register on an idle back end
// throughput: input takes one beat per cycle into a four-deep queue until it is full; the back end
// stalls the queue head during a symbol's registered table read, and an end while the held verdict is not taken
// reset: synchronous active low, clears state and configuration registers, queue and table valid bits
// no clearing pass is needed; input ready is high as soon as reset has emptied the queue
module table_dfa_recognizer_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [tdr_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [tdr_pkg::CHAR_W-1:0] i_cfg_data,
    tdr_in_if.sink                    i_in,
    tdr_out_if.source                 o_out
);
    import tdr_pkg::*;

    // command queue between decode and execute
    logic    q_valid;
    logic    q_pop;
    t_cmd    q_cmd;
    t_cfg_wr cfg;

    // config writes go straight to the back end register file
    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // front: decode each beat, drop unused ops and out-of-range loads,
    // queue the rest so input beats keep flowing while a verdict waits
    tdr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    // back: table updates, state stepping and the verdict register;
    // the queue head waits while each symbol's table read is pending,
    // and an end command also waits while a held verdict is not taken
    tdr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

`ifndef ASSERT_OFF
    // the back end never pops an empty queue
    a_pop_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // an end command is held while the verdict beat is stalled
    a_end_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_cmd.op == OP_END && o_out.valid && !o_out.ready) |-> !q_pop)
        else $error("end command executed over a pending verdict");

    // every executed end command produces a verdict beat
    a_end_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && q_cmd.op == OP_END) |=> o_out.valid)
        else $error("end command gave no verdict");

    // a non-end command never creates a verdict
    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out.valid && !(q_pop && q_cmd.op == OP_END)) |=> !o_out.valid)
        else $error("verdict without end command");
`endif

endmodule

// File: src/tdr_front.sv
`timescale 1ns / 1ps
// front end: decodes input beats, drops no-ops and queues commands
module tdr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tdr_in_if.sink        i_in,
    output logic          o_q_valid,
    output tdr_pkg::t_cmd o_q_cmd,
    input  logic          i_q_pop
);
    import tdr_pkg::*;

    t_cmd              r_q [QDEPTH];
    logic [QAW-1:0]    r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    logic row_ok, col_ok, keep, push;
    t_cmd cmd;

    assign row_ok = (32'(i_in.row_index) < ROWS);
    assign col_ok = (32'(i_in.col_index) < COLS);

    always_comb begin
        cmd.op  = t_op'(i_in.op);
        cmd.row = ROW_AW'(i_in.row_index);
        cmd.col = COL_AW'(i_in.col_index);
        cmd.ch  = i_in.char_value;
        unique case (t_op'(i_in.op))
            OP_ROW:  keep = row_ok;
            OP_COL:  keep = col_ok;
            OP_SET:  keep = row_ok && col_ok;
            OP_FEED: keep = 1'b1;
            OP_END:  keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    assign i_in.ready = (r_cnt != QCNT_W'(QDEPTH));
    assign push       = i_in.valid && i_in.ready && keep;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_cmd    = r_q[r_rp];

    always_comb begin
        case ({push, i_q_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

endmodule

// File: src/tdr_back.sv
`timescale 1ns / 1ps
// back end: holds the tables and registers, steps the state, registers the verdict
module tdr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tdr_pkg::t_cfg_wr i_cfg,
    input  logic            i_q_valid,
    input  tdr_pkg::t_cmd   i_q_cmd,
    output logic            o_q_pop,
    tdr_out_if.source       o_out
);
    import tdr_pkg::*;

    // configuration
    logic [CHAR_W-1:0] r_start;
    logic [FCNT_W-1:0] r_fcnt;
    logic [CHAR_W-1:0] r_fchar [NFINAL];

    // table
    logic [CHAR_W-1:0] r_row_name [ROWS];
    logic [ROWS-1:0]   r_row_vld;
    logic [CHAR_W-1:0] r_col_sym [COLS];
    logic [COLS-1:0]   r_col_vld;

    // next-state store: one write and one registered read per cycle
    logic [CHAR_W-1:0]  r_next [CELLS];
    logic [CELLS-1:0]   r_cell_vld;
    logic [CHAR_W-1:0]  r_rd_data;
    logic               r_rd_vld;
    logic               r_rd_pend;
    logic [CELL_AW-1:0] rd_addr, wr_addr;
    logic               rd_en, do_set;

    // string state
    logic [CHAR_W-1:0] r_cur, n_cur;
    logic              r_in_str, n_in_str;
    logic              r_dead, n_dead;

    // result register
    logic              r_out_vld;
    t_verdict          r_verdict, n_verdict;
    logic [CHAR_W-1:0] r_end;

    logic [CHAR_W-1:0] cur_src;
    logic              row_hit, col_hit, is_fin;
    logic [ROW_AW-1:0] row_sel;
    logic [COL_AW-1:0] col_sel;
    logic [FCNT_W-1:0] fcnt_eff;
    logic [FIDX_W-1:0] fidx;
    logic              do_op, do_end;

    // nothing leaves the queue while a symbol waits for its table read
    assign o_q_pop = i_q_valid && !r_rd_pend &&
                     (i_q_cmd.op != OP_END || !r_out_vld || o_out.ready);
    assign do_op   = o_q_pop;
    assign do_end  = do_op && (i_q_cmd.op == OP_END);
    assign do_set  = do_op && (i_q_cmd.op == OP_SET);

    // state the item works from: the start state opens a new string
    assign cur_src = r_in_str ? r_cur : r_start;

    // lowest valid row named by the current state
    always_comb begin
        row_hit = 1'b0;
        row_sel = '0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (r_row_vld[i] && r_row_name[i] == cur_src) begin
                row_hit = 1'b1;
                row_sel = ROW_AW'(i);
            end
        end
    end

    // lowest valid column named by the symbol
    always_comb begin
        col_hit = 1'b0;
        col_sel = '0;
        for (int i = COLS - 1; i >= 0; i--) begin
            if (r_col_vld[i] && r_col_sym[i] == i_q_cmd.ch) begin
                col_hit = 1'b1;
                col_sel = COL_AW'(i);
            end
        end
    end

    assign rd_addr = {row_sel, col_sel};
    assign wr_addr = {i_q_cmd.row, i_q_cmd.col};
    assign rd_en   = do_op && (i_q_cmd.op == OP_FEED) && !(r_in_str && r_dead) &&
                     row_hit && col_hit;

    // final character match, count saturates at the table size
    assign fcnt_eff = (r_fcnt > FCNT_W'(NFINAL)) ? FCNT_W'(NFINAL) : r_fcnt;

    always_comb begin
        is_fin = 1'b0;
        for (int i = 0; i < NFINAL; i++) begin
            if (FCNT_W'(i) < fcnt_eff && r_fchar[i] == cur_src) begin
                is_fin = 1'b1;
            end
        end
    end

    always_comb begin
        n_cur     = r_cur;
        n_in_str  = r_in_str;
        n_dead    = r_dead;
        n_verdict = is_fin ? V_ACCEPT : V_REJECT;
        if (r_in_str && r_dead) begin
            n_verdict = V_DEAD;
        end
        // a pending symbol's table read lands here, unwritten cells read as zero
        if (r_rd_pend) begin
            n_cur = r_rd_vld ? r_rd_data : '0;
        end
        if (do_op) begin
            case (i_q_cmd.op)
                OP_FEED: begin
                    n_in_str = 1'b1;
                    n_cur    = cur_src;
                    n_dead   = r_in_str && r_dead;
                    if (!(r_in_str && r_dead) && !(row_hit && col_hit)) begin
                        n_dead = 1'b1;
                    end
                end
                OP_END: begin
                    n_in_str = 1'b0;
                    n_dead   = 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign fidx = FIDX_W'(i_cfg.idx - CFG_FA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= '0;
            r_fcnt    <= '0;
            for (int i = 0; i < NFINAL; i++) begin
                r_fchar[i] <= '0;
            end
        end else if (i_cfg.we) begin
            case (i_cfg.idx) inside
                CFG_START: r_start <= i_cfg.data;
                CFG_FCNT:  r_fcnt  <= FCNT_W'(i_cfg.data);
                CFG_FA, CFG_FB, CFG_FC, CFG_FD, CFG_FE: r_fchar[fidx] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld  <= '0;
            r_col_vld  <= '0;
            r_cell_vld <= '0;
            for (int r = 0; r < ROWS; r++) begin
                r_row_name[r] <= '0;
            end
            for (int c = 0; c < COLS; c++) begin
                r_col_sym[c] <= '0;
            end
        end else if (do_op) begin
            case (i_q_cmd.op)
                OP_ROW: begin
                    r_row_name[i_q_cmd.row] <= i_q_cmd.ch;
                    r_row_vld[i_q_cmd.row]  <= 1'b1;
                end
                OP_COL: begin
                    r_col_sym[i_q_cmd.col] <= i_q_cmd.ch;
                    r_col_vld[i_q_cmd.col] <= 1'b1;
                end
                OP_SET:  r_cell_vld[wr_addr] <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_set) begin
            r_next[wr_addr] <= i_q_cmd.ch;
        end
        if (rd_en) begin
            r_rd_data <= r_next[rd_addr];
            r_rd_vld  <= r_cell_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_in_str  <= 1'b0;
            r_dead    <= 1'b0;
            r_out_vld <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_cur     <= n_cur;
            r_in_str  <= n_in_str;
            r_dead    <= n_dead;
            r_rd_pend <= rd_en;
            if (do_end) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_end) begin
            r_verdict <= n_verdict;
            r_end     <= cur_src;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.verdict   = r_verdict;
    assign o_out.end_state = r_end;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the table dfa recognizer: loads, symbol strings and verdicts
module tb;
    import tdr_pkg::*;

    // op codes the block must ignore
    localparam logic [OP_W-1:0]   OP_NOP5  = 3'd5;
    localparam logic [OP_W-1:0]   OP_NOP6  = 3'd6;
    localparam logic [OP_W-1:0]   OP_NOP7  = 3'd7;
    // register index past the end of the list, written once to see it ignored
    localparam logic [CFG_AW-1:0] CFG_NONE = 3'd7;

    // idling modes of the two sides
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SRC  = 1;
    localparam int IDLE_SNK  = 2;
    localparam int IDLE_BOTH = 3;

    // queue depth plus pipeline, with margin: symbols still in flight have no verdict to wait on
    localparam int SETTLE      = QDEPTH + 8;
    localparam int HOLD_LEN    = 120;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 100;
    localparam int MAX_STATES  = 6;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [RIDX_W-1:0] row;
        logic [CIDX_W-1:0] col;
        logic [CHAR_W-1:0] ch;
    } t_in_beat;

    typedef struct packed {
        t_verdict          verdict;
        logic [CHAR_W-1:0] end_state;
    } t_verdict_rec;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              cfg_we   = 1'b0;
    logic [CFG_AW-1:0] cfg_idx  = '0;
    logic [CHAR_W-1:0] cfg_data = '0;

    logic              drv_valid  = 1'b0;
    t_in_beat          drv_beat   = '0;
    logic              sink_ready = 1'b0;
    logic              in_taken   = 1'b0;

    int                src_idle_pct  = 0;
    int                snk_stall_pct = 0;
    int                quiet_cycles  = 0;
    int                mismatches    = 0;

    // long receiver hold-off, requested by toggling hold_req
    logic              hold_req  = 1'b0;
    logic              hold_ack  = 1'b0;
    int                hold_left = 0;

    t_in_beat          cmd_backlog[$];
    t_verdict_rec      expected_verdicts[$];

    // shadow of the recognizer: table, string state and registers
    logic [CHAR_W-1:0] row_name  [ROWS];
    logic              row_live  [ROWS];
    logic [CHAR_W-1:0] col_sym   [COLS];
    logic              col_live  [COLS];
    logic [CHAR_W-1:0] next_char [ROWS*COLS];
    logic [CHAR_W-1:0] cur_char;
    logic              mid_string;
    logic              stuck;
    logic [CHAR_W-1:0] start_char;
    logic [FCNT_W-1:0] final_cnt;
    logic [CHAR_W-1:0] final_char [NFINAL];

    tdr_in_if  in_if ();
    tdr_out_if out_if ();

    assign in_if.valid      = drv_valid;
    assign in_if.op         = drv_beat.op;
    assign in_if.row_index  = drv_beat.row;
    assign in_if.col_index  = drv_beat.col;
    assign in_if.char_value = drv_beat.ch;
    assign out_if.ready     = sink_ready;

    table_dfa_recognizer_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // one accepted input beat through the shadow recognizer
    task automatic step_recognizer(input t_in_beat b, output logic has_res,
                                   output t_verdict_rec res);
        int                r;
        int                k;
        int                n;
        logic [CHAR_W-1:0] fin;
        logic              hit;
        has_res = 1'b0;
        res     = '0;
        case (b.op)
            OP_ROW: begin
                row_name[b.row] = b.ch;
                row_live[b.row] = 1'b1;
            end
            OP_COL: begin
                col_sym[b.col]  = b.ch;
                col_live[b.col] = 1'b1;
            end
            OP_SET: begin
                next_char[int'(b.row) * COLS + int'(b.col)] = b.ch;
            end
            OP_FEED: begin
                // first symbol of a string latches the start state
                if (!mid_string) begin
                    cur_char   = start_char;
                    mid_string = 1'b1;
                    stuck      = 1'b0;
                end
                if (!stuck) begin
                    r = -1;
                    k = -1;
                    // scan downward so the lowest live match is kept
                    for (int i = ROWS - 1; i >= 0; i--)
                        if (row_live[i] && row_name[i] == cur_char) r = i;
                    for (int i = COLS - 1; i >= 0; i--)
                        if (col_live[i] && col_sym[i] == b.ch) k = i;
                    // unknown state or symbol: hold the state where the search failed
                    if (r < 0 || k < 0) stuck = 1'b1;
                    else cur_char = next_char[r * COLS + k];
                end
            end
            OP_END: begin
                // empty string is judged on the start state itself
                fin = mid_string ? cur_char : start_char;
                // counts above the list size saturate
                n   = (final_cnt > NFINAL) ? NFINAL : int'(final_cnt);
                hit = 1'b0;
                for (int i = 0; i < n; i++)
                    if (final_char[i] == fin) hit = 1'b1;
                if (mid_string && stuck) res.verdict = V_DEAD;
                else if (hit) res.verdict = V_ACCEPT;
                else res.verdict = V_REJECT;
                res.end_state = fin;
                has_res       = 1'b1;
                mid_string    = 1'b0;
                stuck         = 1'b0;
                cur_char      = start_char;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [RIDX_W-1:0] row,
                             input logic [CIDX_W-1:0] col, input logic [CHAR_W-1:0] ch);
        t_in_beat beat;
        beat = {op, row, col, ch};
        cmd_backlog.insert(cmd_backlog.size(), beat);
    endtask

    // register write on the port, mirrored into the shadow copy
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CHAR_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_START: start_char    = data;
            CFG_FCNT:  final_cnt     = data[FCNT_W-1:0];
            CFG_FA:    final_char[0] = data;
            CFG_FB:    final_char[1] = data;
            CFG_FC:    final_char[2] = data;
            CFG_FD:    final_char[3] = data;
            CFG_FE:    final_char[4] = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            IDLE_NONE: begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            IDLE_SRC: begin
                src_idle_pct  = 61;
                snk_stall_pct = 0;
            end
            IDLE_SNK: begin
                src_idle_pct  = 0;
                snk_stall_pct = 61;
            end
            default: begin
                src_idle_pct  = 34;
                snk_stall_pct = 34;
            end
        endcase
    endtask

    // all beats sent, all verdicts seen, then let queued symbols drain inside the block
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || drv_valid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // source side: offer the oldest pending beat, hold it until taken
    always @(negedge clk) begin : driver
        logic keep;
        keep = drv_valid && !in_taken;
        if (in_taken) cmd_backlog.delete(0);
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else if (!keep) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                drv_valid <= 1'b1;
                drv_beat  <= cmd_backlog[0];
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // sink side: random stalls, forced low during a hold-off
    always @(negedge clk) begin : sink
        if (!rst_n) begin
            sink_ready <= 1'b0;
        end else begin
            sink_ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(negedge clk) begin : hold_counter
        if (hold_req != hold_ack) begin
            hold_left <= HOLD_LEN;
            hold_ack  <= hold_req;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // both handshakes sampled at the rising edge; also the stall watchdog
    always @(posedge clk) begin : monitor
        t_in_beat     seen;
        t_verdict_rec pred;
        t_verdict_rec want;
        logic         has_res;
        if (!rst_n) begin
            in_taken     <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            in_taken <= in_if.valid && in_if.ready;
            if (out_if.valid && out_if.ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("verdict beat with none due, verdict",
                                    32'(out_if.verdict), 0);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (out_if.verdict !== want.verdict)
                        report_mismatch("verdict", 32'(out_if.verdict), 32'(want.verdict));
                    if (out_if.end_state !== want.end_state)
                        report_mismatch("end_state", 32'(out_if.end_state),
                                        32'(want.end_state));
                end
            end
            if (in_if.valid && in_if.ready) begin
                seen = {in_if.op, in_if.row_index, in_if.col_index, in_if.char_value};
                step_recognizer(seen, has_res, pred);
                if (has_res) expected_verdicts.insert(expected_verdicts.size(), pred);
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int                budget;
        int                len;
        int                ns;
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] pick;
        logic [FCNT_W-1:0] fcnt;
        logic [CHAR_W-1:0] st_char [MAX_STATES];
        logic [RIDX_W-1:0] st_row  [MAX_STATES];
        logic [CHAR_W-1:0] sym     [COLS];

        // shadow starts at its reset image
        for (int i = 0; i < ROWS; i++) begin
            row_name[i] = '0;
            row_live[i] = 1'b0;
        end
        for (int i = 0; i < COLS; i++) begin
            col_sym[i]  = '0;
            col_live[i] = 1'b0;
            sym[i]      = '0;
        end
        for (int i = 0; i < ROWS * COLS; i++) next_char[i] = '0;
        for (int i = 0; i < NFINAL; i++) final_char[i] = '0;
        cur_char   = '0;
        mid_string = 1'b0;
        stuck      = 1'b0;
        start_char = '0;
        final_cnt  = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // first setting: start on 0x00, only 0xff is final
        set_idling(IDLE_NONE);
        write_reg(CFG_START, 8'h00);
        write_reg(CFG_FCNT, 8'd1);
        write_reg(CFG_FA, 8'hFF);
        write_reg(CFG_FB, 8'h00);
        write_reg(CFG_FC, 8'h5A);
        write_reg(CFG_FD, 8'hA5);
        write_reg(CFG_FE, 8'h01);
        write_reg(CFG_NONE, 8'hFF);

        // empty string right after reset
        queue_cmd(OP_END, 4'h0, 2'd0, 8'h00);
        // symbols on an empty table go dead, the second is ignored
        queue_cmd(OP_FEED, 4'h0, 2'd0, 8'h41);
        queue_cmd(OP_FEED, 4'hF, 2'd3, 8'h42);
        queue_cmd(OP_END, 4'hF, 2'd3, 8'hFF);
        // extreme rows and columns, duplicate names so the lowest must win
        queue_cmd(OP_ROW, 4'h0, 2'd0, 8'h00);
        queue_cmd(OP_ROW, 4'hF, 2'd3, 8'hFF);
        queue_cmd(OP_ROW, 4'h3, 2'd1, 8'h00);
        queue_cmd(OP_COL, 4'h0, 2'd0, 8'h00);
        queue_cmd(OP_COL, 4'hF, 2'd3, 8'hFF);
        queue_cmd(OP_COL, 4'h5, 2'd1, 8'hFF);
        queue_cmd(OP_SET, 4'h0, 2'd1, 8'hFF);
        queue_cmd(OP_SET, 4'h3, 2'd1, 8'h00);
        queue_cmd(OP_SET, 4'hF, 2'd0, 8'h00);
        queue_cmd(OP_SET, 4'hF, 2'd3, 8'h12);
        queue_cmd(OP_SET, 4'hF, 2'd1, 8'hFF);
        // ends in the final state
        queue_cmd(OP_FEED, 4'h0, 2'd0, 8'hFF);
        queue_cmd(OP_FEED, 4'h0, 2'd0, 8'hFF);
        queue_cmd(OP_END, 4'h0, 2'd0, 8'h00);
        // ends in a state that is final only beyond the count
        queue_cmd(OP_FEED, 4'h0, 2'd0, 8'hFF);
        queue_cmd(OP_FEED, 4'h0, 2'd0, 8'h00);
        queue_cmd(OP_END, 4'h0, 2'd0, 8'h00);
        // spare op codes do nothing
        queue_cmd(OP_NOP5, 4'hF, 2'd3, 8'hFF);
        queue_cmd(OP_NOP6, 4'h0, 2'd0, 8'h00);
        queue_cmd(OP_NOP7, 4'hA, 2'd2, 8'h55);
        // unknown symbol keeps the state where the lookup failed
        queue_cmd(OP_FEED, 4'h0, 2'd0, 8'h77);
        queue_cmd(OP_END, 4'h0, 2'd0, 8'h00);
        wait_drained();

        // random phases: fresh small dfa each time, idling mode rotates
        for (int ph = 0; ph < PHASES; ph++) begin
            set_idling(ph % 4);
            ns = $urandom_range(2, MAX_STATES);
            for (int s = 0; s < MAX_STATES; s++) begin
                st_char[s] = CHAR_W'($urandom_range(0, 255));
                st_row[s]  = RIDX_W'($urandom_range(0, ROWS - 1));
            end
            if (ph == 3) st_char[0] = 8'hFF;
            if (ph == 4) st_char[0] = 8'h00;
            for (int c = 0; c < COLS; c++) sym[c] = CHAR_W'($urandom_range(0, 255));

            // registers: start mostly on a named state, counts at and past the edges
            pick = st_char[$urandom_range(0, ns - 1)];
            if (ph == 3) pick = 8'hFF;
            else if ($urandom_range(9) == 0) pick = CHAR_W'($urandom_range(0, 255));
            write_reg(CFG_START, pick);
            if (ph == 0) fcnt = 3'd5;
            else if (ph == 1) fcnt = 3'd7;
            else if (ph == 2) fcnt = 3'd0;
            else fcnt = FCNT_W'($urandom_range(0, 7));
            write_reg(CFG_FCNT, {{(CHAR_W-FCNT_W){1'b0}}, fcnt});
            for (int f = 0; f < NFINAL; f++) begin
                if ($urandom_range(9) < 6) pick = st_char[$urandom_range(0, ns - 1)];
                else pick = CHAR_W'($urandom_range(0, 255));
                write_reg(CFG_FA + CFG_AW'(f), pick);
            end

            // table load; unused fields carry random bits
            for (int s = 0; s < ns; s++)
                queue_cmd(OP_ROW, st_row[s], CIDX_W'($urandom_range(0, COLS - 1)),
                          st_char[s]);
            for (int c = 0; c < COLS; c++)
                queue_cmd(OP_COL, RIDX_W'($urandom_range(0, ROWS - 1)), CIDX_W'(c), sym[c]);
            for (int s = 0; s < ns; s++) begin
                for (int c = 0; c < COLS; c++) begin
                    if ($urandom_range(9) == 0) pick = CHAR_W'($urandom_range(0, 255));
                    else pick = st_char[$urandom_range(0, ns - 1)];
                    queue_cmd(OP_SET, st_row[s], CIDX_W'(c), pick);
                end
            end
            budget = ns * (COLS + 1) + COLS;

            // mostly well-formed strings over the known symbols, some noise
            while (budget < PHASE_ITEMS) begin
                if ($urandom_range(9) == 0) begin
                    op = OP_W'($urandom_range(0, 7));
                    queue_cmd(op, RIDX_W'($urandom_range(0, ROWS - 1)),
                              CIDX_W'($urandom_range(0, COLS - 1)),
                              CHAR_W'($urandom_range(0, 255)));
                    if (op <= OP_END) budget++;
                end else begin
                    len = $urandom_range(0, 8);
                    for (int j = 0; j < len; j++) begin
                        // table edit in the middle of a string
                        if ($urandom_range(29) == 0) begin
                            queue_cmd(OP_SET, st_row[$urandom_range(0, ns - 1)],
                                      CIDX_W'($urandom_range(0, COLS - 1)),
                                      st_char[$urandom_range(0, ns - 1)]);
                            budget++;
                        end
                        if ($urandom_range(11) == 0) pick = CHAR_W'($urandom_range(0, 255));
                        else pick = sym[$urandom_range(0, COLS - 1)];
                        queue_cmd(OP_FEED, RIDX_W'($urandom_range(0, ROWS - 1)),
                                  CIDX_W'($urandom_range(0, COLS - 1)), pick);
                        budget++;
                    end
                    queue_cmd(OP_END, RIDX_W'($urandom_range(0, ROWS - 1)),
                              CIDX_W'($urandom_range(0, COLS - 1)),
                              CHAR_W'($urandom_range(0, 255)));
                    budget++;
                end
            end
            // sender pauses here until every verdict is back
            wait_drained();
        end

        // back-pressure: receiver holds off while ends keep coming, input must stall
        set_idling(IDLE_NONE);
        for (int j = 0; j < 10; j++) begin
            queue_cmd(OP_FEED, RIDX_W'($urandom_range(0, ROWS - 1)),
                      CIDX_W'($urandom_range(0, COLS - 1)),
                      sym[$urandom_range(0, COLS - 1)]);
            queue_cmd(OP_END, RIDX_W'($urandom_range(0, ROWS - 1)),
                      CIDX_W'($urandom_range(0, COLS - 1)),
                      CHAR_W'($urandom_range(0, 255)));
        end
        for (int j = 0; j < 16; j++)
            queue_cmd(OP_END, RIDX_W'($urandom_range(0, ROWS - 1)),
                      CIDX_W'($urandom_range(0, COLS - 1)),
                      CHAR_W'($urandom_range(0, 255)));
        hold_req = ~hold_req;
        wait_drained();

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/tdr_pkg.sv
src/tdr_in_if.sv
src/tdr_out_if.sv
src/tdr_front.sv
src/tdr_back.sv
src/table_dfa_recognizer_top.sv
test/tb.sv
